// File: rtl/iabst_pkg.sv
// Package for the implicit-array BST engine: result codes, read-address
// select, controller/datapath command and status structs, FSM state type.
// No dependencies.
`default_nettype none

package iabst_pkg;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_NO_ROOM   = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // source of the key/occupancy store read address
  typedef enum logic [1:0] {
    RA_CUR   = 2'd0,
    RA_INPUT = 2'd1,
    RA_CHILD = 2'd2
  } rd_sel_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    logic    start;
    logic    clr_step;
    logic    ins_step;
    logic    del_check;
    logic    del_step;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic is_delete;
    logic node_oob;
    logic walk_done;
    logic chk_empty;
    logic del_last;
    logic clr_last;
  } sts_t;

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_INS_WALK  = 7'b0000100,
    S_DEL_CHECK = 7'b0001000,
    S_DEL_READ  = 7'b0010000,
    S_DEL_WRITE = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/iabst_if.sv
// Request and result channel interfaces of the implicit-array BST engine.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface iabst_req_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic signed [7:0] key;
  logic        [7:0] node_slot;

  modport source (output valid, output mode, output key, output node_slot, input ready);
  modport sink   (input valid, input mode, input key, input node_slot, output ready);
endinterface

interface iabst_res_if;
  logic              valid;
  logic              ready;
  logic        [2:0] status;
  logic        [7:0] slot;
  logic signed [3:0] tree_height;

  modport source (output valid, output status, output slot, output tree_height, input ready);
  modport sink   (input valid, input status, input slot, input tree_height, output ready);
endinterface

`default_nettype wire

// File: rtl/iabst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module iabst_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 255
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/iabst_ctrl.sv
// Sequencing state machine of the implicit-array BST engine.
// Depends on iabst_pkg.
`default_nettype none

module iabst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire iabst_pkg::sts_t sts,
  output iabst_pkg::cmd_t    cmd
);
  import iabst_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = RA_CUR;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.rd_sel = RA_INPUT;
        if (accept) begin
          cmd.start = 1'b1;
          if (!sts.is_delete) begin
            state_nxt = S_INS_WALK;
          end else if (sts.node_oob) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DEL_CHECK;
          end
        end
      end
      S_INS_WALK: begin
        cmd.rd_sel   = RA_CHILD;
        cmd.ins_step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DEL_CHECK: begin
        cmd.del_check = 1'b1;
        state_nxt     = sts.chk_empty ? S_DONE : S_DEL_READ;
      end
      S_DEL_READ: begin
        state_nxt = S_DEL_WRITE;
      end
      S_DEL_WRITE: begin
        cmd.del_step = 1'b1;
        state_nxt    = sts.del_last ? S_DONE : S_DEL_READ;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/iabst_dpath.sv
// Datapath of the implicit-array BST engine: key/occupancy store, walk and
// sweep pointers, per-level occupancy counts, result registers.
// Depends on iabst_pkg and iabst_ram.
`default_nettype none

module iabst_dpath #(
  parameter int SLOT_COUNT = 255
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire iabst_pkg::cmd_t   cmd,
  output iabst_pkg::sts_t        sts,
  input  wire logic              in_mode,
  input  wire logic signed [7:0] in_key,
  input  wire logic        [7:0] in_node_slot,
  output logic             [2:0] out_status,
  output logic             [7:0] out_slot,
  output logic signed      [3:0] out_tree_height
);
  import iabst_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT + 1);  // slot number width
  localparam int AW = $clog2(SLOT_COUNT);      // store address width
  localparam int NL = SW;                      // number of tree levels
  localparam int LW = $clog2(NL);
  localparam int HW = LW + 1;                  // signed height width
  localparam int CW = SW;                      // per-level count width
  localparam int PW = SW + 2;                  // width of child/next-level values

  logic signed [7:0]  key_r;
  logic        [7:0]  node_r;
  logic        [SW:0] cur_r;
  logic        [SW:0] lo_r;
  logic        [SW:0] hi_r;
  logic      [LW-1:0] level_r;
  logic      [CW-1:0] cnt_r [NL];
  logic         [2:0] res_status_r;
  logic         [7:0] res_slot_r;
  logic         [2:0] out_status_r;
  logic         [7:0] out_slot_r;
  logic signed  [3:0] out_height_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic    [8:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic    [8:0] ram_rdata;

  logic              rd_occ;
  logic signed [7:0] rd_key;
  logic              key_lt;
  logic              key_eq;
  logic              child_oob;
  logic     [PW-1:0] lo_next;
  logic     [PW-1:0] hi_next;
  logic       [SW:0] top;
  logic              slot_last;
  logic              level_last;
  logic        [8:0] node_p1;
  logic        [3:0] node_lvl;
  logic signed [HW-1:0] height_c;
  logic signed [HW+3:0] height_x;
  logic signed    [3:0] height_sat;

  iabst_ram #(
    .WIDTH (9),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_occ    = ram_rdata[8];
  assign rd_key    = $signed(ram_rdata[7:0]);
  assign key_lt    = key_r < rd_key;
  assign key_eq    = key_r == rd_key;
  assign lo_next   = PW'({lo_r, 1'b0}) + PW'(1);
  assign hi_next   = PW'({hi_r, 1'b0}) + PW'(2);
  assign top       = (32'(hi_r) < 32'(SLOT_COUNT - 1)) ? hi_r : (SW + 1)'(SLOT_COUNT - 1);
  assign slot_last = (cur_r == top);
  assign level_last = 32'(lo_next) >= 32'(SLOT_COUNT);

  // child slot: 2i+1 on a smaller key, 2i+2 on a larger one
  logic [PW-1:0] child_sum;
  assign child_sum = PW'({cur_r, 1'b0}) + (key_lt ? PW'(1) : PW'(2));
  assign child_oob = 32'(child_sum) >= 32'(SLOT_COUNT);

  // level of the delete root: index of the leading one of slot + 1
  assign node_p1 = {1'b0, node_r} + 9'd1;
  always_comb begin
    node_lvl = '0;
    for (int i = 0; i < 9; i++) begin
      if (node_p1[i]) begin
        node_lvl = 4'(i);
      end
    end
  end

  // height: deepest level that holds at least one key
  always_comb begin
    height_c = '1;
    for (int l = 0; l < NL; l++) begin
      if (cnt_r[l] != '0) begin
        height_c = HW'(l);
      end
    end
  end
  assign height_x   = (HW + 4)'(height_c);
  assign height_sat = (height_x > (HW + 4)'(7)) ? 4'sd7 : $signed(height_x[3:0]);

  always_comb begin
    case (cmd.rd_sel)
      RA_INPUT: ram_raddr = in_mode ? AW'(in_node_slot) : '0;
      RA_CHILD: ram_raddr = AW'(child_sum);
      RA_CUR:   ram_raddr = AW'(cur_r);
      default:  ram_raddr = AW'(cur_r);
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(cur_r);
    ram_wdata = '0;
    if (cmd.clr_step || cmd.del_step) begin
      ram_we = 1'b1;
    end else if (cmd.ins_step && !rd_occ) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, key_r};
    end
  end

  assign sts.is_delete = in_mode;
  assign sts.node_oob  = 32'(in_node_slot) >= 32'(SLOT_COUNT);
  assign sts.walk_done = !rd_occ || key_eq || child_oob;
  assign sts.chk_empty = !rd_occ;
  assign sts.del_last  = slot_last && level_last;
  assign sts.clr_last  = 32'(cur_r) == 32'(SLOT_COUNT - 1);

  // pointers and level counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      level_r <= '0;
      for (int l = 0; l < NL; l++) begin
        cnt_r[l] <= '0;
      end
    end else begin
      if (cmd.clr_step) begin
        cur_r <= sts.clr_last ? '0 : cur_r + 1'b1;
      end
      if (cmd.start) begin
        cur_r   <= '0;
        level_r <= '0;
      end
      if (cmd.ins_step) begin
        if (!rd_occ) begin
          for (int l = 0; l < NL; l++) begin
            if (level_r == LW'(l)) begin
              cnt_r[l] <= cnt_r[l] + 1'b1;
            end
          end
        end else if (!key_eq && !child_oob) begin
          cur_r   <= (SW + 1)'(child_sum);
          level_r <= level_r + 1'b1;
        end
      end
      if (cmd.del_check) begin
        cur_r   <= (SW + 1)'(node_r);
        level_r <= LW'(node_lvl);
      end
      if (cmd.del_step) begin
        if (rd_occ) begin
          for (int l = 0; l < NL; l++) begin
            if (level_r == LW'(l)) begin
              cnt_r[l] <= cnt_r[l] - 1'b1;
            end
          end
        end
        if (!slot_last) begin
          cur_r <= cur_r + 1'b1;
        end else if (!level_last) begin
          cur_r   <= (SW + 1)'(lo_next);
          level_r <= level_r + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r        <= in_key;
      node_r       <= in_node_slot;
      res_status_r <= ST_EMPTY;
      res_slot_r   <= in_node_slot;
    end
    if (cmd.ins_step) begin
      if (!rd_occ) begin
        res_status_r <= ST_INSERTED;
        res_slot_r   <= 8'(cur_r);
      end else if (key_eq) begin
        res_status_r <= ST_DUPLICATE;
        res_slot_r   <= 8'(cur_r);
      end else if (child_oob) begin
        res_status_r <= ST_NO_ROOM;
        res_slot_r   <= '0;
      end
    end
    if (cmd.del_check) begin
      lo_r <= (SW + 1)'(node_r);
      hi_r <= (SW + 1)'(node_r);
    end
    if (cmd.del_step && slot_last && !level_last) begin
      lo_r <= (SW + 1)'(lo_next);
      hi_r <= (SW + 1)'(hi_next);
    end
    if (cmd.del_step && sts.del_last) begin
      res_status_r <= ST_DELETED;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_height_r <= height_sat;
    end
  end

  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_tree_height = out_height_r;

endmodule

`default_nettype wire

// File: rtl/implicit_array_bst_engine.sv
// Implicit-array binary search tree engine, top level.
// Depends on iabst_pkg, iabst_if, iabst_ctrl, iabst_dpath, iabst_ram.
//
// Keeps a binary search tree of signed 8-bit keys in heap layout: slot 0 is
// the root and slot i has children 2i+1 and 2i+2. An insert request walks
// from the root, one tree level per clock, and places its key in the first
// empty slot on its path, reports a duplicate, or reports no room when the
// walk leaves the store. A delete request empties the whole subtree under
// node_slot, sweeping each level of the subtree (clipped to the store) slot
// by slot, reading each slot and then clearing it; a delete of an empty or
// out-of-range slot finishes without a sweep. Each request returns exactly
// one result carrying the tree height afterwards, kept by per-level
// occupancy counters so no full rescan is needed. One request is in flight
// at a time; a finished result may wait in the output register while the
// next request is taken. After reset the block sweeps the store clear, slot
// by slot, and holds in_req.ready low meanwhile.
`default_nettype none

module implicit_array_bst_engine #(
  parameter int SLOT_COUNT = 255
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  iabst_req_if.sink  in_req,
  iabst_res_if.source out_res
);
  import iabst_pkg::*;

  cmd_t cmd;   // controller -> datapath
  sts_t sts;   // datapath -> controller

  // sequencing: store clear, request accept, walk, subtree sweep, result hand-off
  iabst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store, pointers, level counters and result registers
  iabst_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_req.mode),
    .in_key          (in_req.key),
    .in_node_slot    (in_req.node_slot),
    .out_status      (out_res.status),
    .out_slot        (out_res.slot),
    .out_tree_height (out_res.tree_height)
  );

endmodule

`default_nettype wire

// File: rtl/iabst_checker.sv
// Port-level checks for the implicit-array BST engine, bound to the top level.
// Depends on iabst_pkg.
`default_nettype none

module iabst_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic        [2:0] out_status,
  input wire logic        [7:0] out_slot,
  input wire logic signed [3:0] out_tree_height
);
  import iabst_pkg::*;

  // one request in flight: ready drops straight after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another was in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot)
      && $stable(out_tree_height))
    else $error("stalled result changed");

  // status code within the defined set
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_EMPTY)
    else $error("undefined status code");

  // a tree that holds the inserted or found key is not empty
  a_height_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_INSERTED || out_status == ST_DUPLICATE)
      |-> !out_tree_height[3])
    else $error("empty height reported with a key present");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind implicit_array_bst_engine iabst_checker u_iabst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_status      (out_res.status),
  .out_slot        (out_res.slot),
  .out_tree_height (out_res.tree_height)
);

`default_nettype wire
